@@ hdl/rv32imf_instruction_decoder_core_defines.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef RV32IMF_INSTRUCTION_DECODER_CORE_DEFINES_SVH
`define RV32IMF_INSTRUCTION_DECODER_CORE_DEFINES_SVH

// Checks that b holds in the same cycle whenever a holds.
`define RVDEC_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("rvdec assertion failed");

// Checks that b follows a in a later cycle.
`define RVDEC_ASSERT_AFTER3(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> ##2 (b)) \
    else $error("rvdec latency assertion failed");

`endif

@@ hdl/rvdec_pkg.sv @@
// Package with the shared types and operation codes of the instruction decoder.
`timescale 1ns / 1ps
`default_nettype none
package rvdec_pkg;

  localparam int unsigned XlenW = 32;
  localparam int unsigned OpW   = 7;
  localparam int unsigned RegW  = 5;

  localparam logic [OpW-1:0] OP_LB = 7'd0, OP_LH = 7'd1, OP_LW = 7'd2, OP_LBU = 7'd3;
  localparam logic [OpW-1:0] OP_LHU = 7'd4, OP_ADDI = 7'd5, OP_SLLI = 7'd6;
  localparam logic [OpW-1:0] OP_SLTI = 7'd7, OP_SLTIU = 7'd8, OP_XORI = 7'd9;
  localparam logic [OpW-1:0] OP_SRAI = 7'd10, OP_SRLI = 7'd11, OP_ORI = 7'd12;
  localparam logic [OpW-1:0] OP_ANDI = 7'd13, OP_ADD_UPPER_PC = 7'd14, OP_SB = 7'd15;
  localparam logic [OpW-1:0] OP_SH = 7'd16, OP_SW = 7'd17, OP_ADD = 7'd18;
  localparam logic [OpW-1:0] OP_SLL = 7'd19, OP_SLT = 7'd20, OP_SLTU = 7'd21;
  localparam logic [OpW-1:0] OP_XOR = 7'd22, OP_SRL = 7'd23, OP_OR = 7'd24;
  localparam logic [OpW-1:0] OP_AND = 7'd25, OP_SUB = 7'd26, OP_SRA = 7'd27;
  localparam logic [OpW-1:0] OP_MUL = 7'd28, OP_MULH = 7'd29, OP_MULHU = 7'd30;
  localparam logic [OpW-1:0] OP_MULHSU = 7'd31, OP_DIV = 7'd32, OP_DIVU = 7'd33;
  localparam logic [OpW-1:0] OP_REM = 7'd34, OP_REMU = 7'd35, OP_LUI = 7'd36;
  localparam logic [OpW-1:0] OP_BEQ = 7'd37, OP_BNE = 7'd38, OP_BLT = 7'd39;
  localparam logic [OpW-1:0] OP_BGE = 7'd40, OP_BLTU = 7'd41, OP_BGEU = 7'd42;
  localparam logic [OpW-1:0] OP_JALR = 7'd43, OP_JAL = 7'd44, OP_ECALL = 7'd45;
  localparam logic [OpW-1:0] OP_EBREAK = 7'd46, OP_CSRRW = 7'd47, OP_CSRRS = 7'd48;
  localparam logic [OpW-1:0] OP_CSRRC = 7'd49, OP_CSRRWI = 7'd50, OP_CSRRSI = 7'd51;
  localparam logic [OpW-1:0] OP_CSRRCI = 7'd52, OP_FLW = 7'd53, OP_FSW = 7'd54;
  localparam logic [OpW-1:0] OP_FADD = 7'd55, OP_FSUB = 7'd56, OP_FMUL = 7'd57;
  localparam logic [OpW-1:0] OP_FDIV = 7'd58, OP_FSQRT = 7'd59, OP_FCVT_W_S = 7'd60;
  localparam logic [OpW-1:0] OP_FCVT_WU_S = 7'd61, OP_FMV_X_W = 7'd62;
  localparam logic [OpW-1:0] OP_FCLASS = 7'd63, OP_FCVT_S_W = 7'd64;
  localparam logic [OpW-1:0] OP_FCVT_S_WU = 7'd65, OP_FMV_W_X = 7'd66;
  localparam logic [OpW-1:0] OP_FSGNJ = 7'd67, OP_FSGNJN = 7'd68, OP_FSGNJX = 7'd69;
  localparam logic [OpW-1:0] OP_FMIN = 7'd70, OP_FMAX = 7'd71, OP_FEQ = 7'd72;
  localparam logic [OpW-1:0] OP_FLT = 7'd73, OP_FLE = 7'd74, OP_FMADD = 7'd75;
  localparam logic [OpW-1:0] OP_FMSUB = 7'd76, OP_FNMSUB = 7'd77, OP_FNMADD = 7'd78;

  localparam logic [1:0] CFG_MUL_DIV = 2'd0;
  localparam logic [1:0] CFG_CSR     = 2'd1;
  localparam logic [1:0] CFG_FLOAT   = 2'd2;

  typedef enum logic [3:0] {
    GRP_ILLEGAL, GRP_LOAD, GRP_OPIMM, GRP_AUIPC, GRP_STORE, GRP_OP, GRP_LUI,
    GRP_BRANCH, GRP_JALR, GRP_JAL, GRP_SYSTEM, GRP_FLW, GRP_FSW, GRP_OPFP, GRP_FMA
  } group_e;

  typedef enum logic [3:0] {
    FMT_NONE, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J, FMT_R, FMT_R4, FMT_SYS
  } fmt_e;

  typedef struct packed {
    logic             vld;
    logic [XlenW-1:0] inst;
    logic [XlenW-1:0] pc;
    group_e           grp;
  } s1_t;

  typedef struct packed {
    logic             vld;
    logic [XlenW-1:0] inst;
    logic [XlenW-1:0] pc;
    logic             ok;
    logic [OpW-1:0]   op;
    fmt_e             fmt;
  } s2_t;

endpackage
`default_nettype wire

@@ hdl/rvdec_classify.sv @@
// First decode stage: registers the word and sorts it into its major opcode group.
`timescale 1ns / 1ps
`default_nettype none
module rvdec_classify
  import rvdec_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [XlenW-1:0] inst_i,
  input  wire logic [XlenW-1:0] pc_i,
  input  wire logic             en_float_i,
  output s1_t                   s1_o
);

  logic             vld_q;
  logic [XlenW-1:0] inst_q, pc_q;
  group_e           grp_d, grp_q;

  always_comb begin
    grp_d = GRP_ILLEGAL;
    if (inst_i[1:0] == 2'b11) begin
      case (inst_i[6:2])
        5'd0:  grp_d = GRP_LOAD;
        5'd4:  grp_d = GRP_OPIMM;
        5'd5:  grp_d = GRP_AUIPC;
        5'd8:  grp_d = GRP_STORE;
        5'd12: grp_d = GRP_OP;
        5'd13: grp_d = GRP_LUI;
        5'd24: grp_d = GRP_BRANCH;
        5'd25: grp_d = GRP_JALR;
        5'd27: grp_d = GRP_JAL;
        5'd28: grp_d = GRP_SYSTEM;
        5'd1:  grp_d = en_float_i ? GRP_FLW : GRP_ILLEGAL;
        5'd9:  grp_d = en_float_i ? GRP_FSW : GRP_ILLEGAL;
        5'd20: grp_d = en_float_i ? GRP_OPFP : GRP_ILLEGAL;
        5'd16, 5'd17, 5'd18, 5'd19: grp_d = en_float_i ? GRP_FMA : GRP_ILLEGAL;
        default: grp_d = GRP_ILLEGAL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    inst_q <= inst_i;
    pc_q   <= pc_i;
    grp_q  <= grp_d;
  end

  assign s1_o = '{vld: vld_q, inst: inst_q, pc: pc_q, grp: grp_q};

endmodule
`default_nettype wire

@@ hdl/rvdec_opsel.sv @@
// Second decode stage: selects the operation number and the field format, and flags illegal words.
`timescale 1ns / 1ps
`default_nettype none
module rvdec_opsel
  import rvdec_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire s1_t  s1_i,
  input  wire logic en_mul_div_i,
  input  wire logic en_csr_i,
  output s2_t       s2_o
);

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_FADD   = 7'h00;
  localparam logic [6:0] F7_FSUB   = 7'h04;
  localparam logic [6:0] F7_FMUL   = 7'h08;
  localparam logic [6:0] F7_FDIV   = 7'h0C;
  localparam logic [6:0] F7_FSQRT  = 7'h2C;
  localparam logic [6:0] F7_FCVTWS = 7'h60;
  localparam logic [6:0] F7_FMVXW  = 7'h70;
  localparam logic [6:0] F7_FCVTSW = 7'h68;
  localparam logic [6:0] F7_FMVWX  = 7'h78;
  localparam logic [6:0] F7_FSGNJ  = 7'h10;
  localparam logic [6:0] F7_FMINMX = 7'h14;
  localparam logic [6:0] F7_FCMP   = 7'h50;

  logic [2:0]       f3;
  logic [6:0]       f7;
  logic [RegW-1:0]  r2;
  logic             ok_d, ok_q, vld_q;
  logic [OpW-1:0]   op_d, op_q;
  fmt_e             fmt_d, fmt_q;
  logic [XlenW-1:0] inst_q, pc_q;

  assign f3 = s1_i.inst[14:12];
  assign f7 = s1_i.inst[31:25];
  assign r2 = s1_i.inst[24:20];

  always_comb begin
    ok_d  = 1'b1;
    op_d  = OP_LB;
    fmt_d = FMT_NONE;
    case (s1_i.grp)
      GRP_LOAD: begin
        fmt_d = FMT_I;
        case (f3)
          3'd0: op_d = OP_LB;
          3'd1: op_d = OP_LH;
          3'd2: op_d = OP_LW;
          3'd4: op_d = OP_LBU;
          3'd5: op_d = OP_LHU;
          default: ok_d = 1'b0;
        endcase
      end
      GRP_OPIMM: begin
        fmt_d = FMT_I;
        case (f3)
          3'd0: op_d = OP_ADDI;
          3'd1: op_d = OP_SLLI;
          3'd2: op_d = OP_SLTI;
          3'd3: op_d = OP_SLTIU;
          3'd4: op_d = OP_XORI;
          3'd5: op_d = (f7 != 7'd0) ? OP_SRAI : OP_SRLI;
          3'd6: op_d = OP_ORI;
          default: op_d = OP_ANDI;
        endcase
      end
      GRP_AUIPC: begin
        fmt_d = FMT_U;
        op_d  = OP_ADD_UPPER_PC;
      end
      GRP_LUI: begin
        fmt_d = FMT_U;
        op_d  = OP_LUI;
      end
      GRP_STORE: begin
        fmt_d = FMT_S;
        case (f3)
          3'd0: op_d = OP_SB;
          3'd1: op_d = OP_SH;
          3'd2: op_d = OP_SW;
          default: ok_d = 1'b0;
        endcase
      end
      GRP_OP: begin
        fmt_d = FMT_R;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: op_d = OP_ADD;
            3'd1: op_d = OP_SLL;
            3'd2: op_d = OP_SLT;
            3'd3: op_d = OP_SLTU;
            3'd4: op_d = OP_XOR;
            3'd5: op_d = OP_SRL;
            3'd6: op_d = OP_OR;
            default: op_d = OP_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          case (f3)
            3'd0: op_d = OP_SUB;
            3'd5: op_d = OP_SRA;
            default: ok_d = 1'b0;
          endcase
        end else if (f7 == F7_MULDIV && en_mul_div_i) begin
          case (f3)
            3'd0: op_d = OP_MUL;
            3'd1: op_d = OP_MULH;
            3'd2: op_d = OP_MULHSU;
            3'd3: op_d = OP_MULHU;
            3'd4: op_d = OP_DIV;
            3'd5: op_d = OP_DIVU;
            3'd6: op_d = OP_REM;
            default: op_d = OP_REMU;
          endcase
        end else begin
          ok_d = 1'b0;
        end
      end
      GRP_BRANCH: begin
        fmt_d = FMT_B;
        case (f3)
          3'd0: op_d = OP_BEQ;
          3'd1: op_d = OP_BNE;
          3'd4: op_d = OP_BLT;
          3'd5: op_d = OP_BGE;
          3'd6: op_d = OP_BLTU;
          3'd7: op_d = OP_BGEU;
          default: ok_d = 1'b0;
        endcase
      end
      GRP_JALR: begin
        fmt_d = FMT_I;
        op_d  = OP_JALR;
      end
      GRP_JAL: begin
        fmt_d = FMT_J;
        op_d  = OP_JAL;
      end
      GRP_SYSTEM: begin
        fmt_d = FMT_SYS;
        if (f3 == 3'd0) begin
          if (s1_i.inst[31:20] == 12'd0) begin
            op_d = OP_ECALL;
          end else if (s1_i.inst[31:20] == 12'd1) begin
            op_d = OP_EBREAK;
          end else begin
            ok_d = 1'b0;
          end
        end else if (en_csr_i) begin
          case (f3)
            3'd1: op_d = OP_CSRRW;
            3'd2: op_d = OP_CSRRS;
            3'd3: op_d = OP_CSRRC;
            3'd5: op_d = OP_CSRRWI;
            3'd6: op_d = OP_CSRRSI;
            3'd7: op_d = OP_CSRRCI;
            default: ok_d = 1'b0;
          endcase
        end else begin
          ok_d = 1'b0;
        end
      end
      GRP_FLW: begin
        fmt_d = FMT_I;
        op_d  = OP_FLW;
      end
      GRP_FSW: begin
        fmt_d = FMT_S;
        op_d  = OP_FSW;
      end
      GRP_OPFP: begin
        fmt_d = FMT_R;
        case (f7)
          F7_FADD:  op_d = OP_FADD;
          F7_FSUB:  op_d = OP_FSUB;
          F7_FMUL:  op_d = OP_FMUL;
          F7_FDIV:  op_d = OP_FDIV;
          F7_FSQRT: op_d = OP_FSQRT;
          F7_FCVTWS: begin
            if (r2 == 5'd0) begin
              op_d = OP_FCVT_W_S;
            end else if (r2 == 5'd1) begin
              op_d = OP_FCVT_WU_S;
            end else begin
              ok_d = 1'b0;
            end
          end
          F7_FMVXW: begin
            if (f3 == 3'd0) begin
              op_d = OP_FMV_X_W;
            end else if (f3 == 3'd1) begin
              op_d = OP_FCLASS;
            end else begin
              ok_d = 1'b0;
            end
          end
          F7_FCVTSW: begin
            if (r2 == 5'd0) begin
              op_d = OP_FCVT_S_W;
            end else if (r2 == 5'd1) begin
              op_d = OP_FCVT_S_WU;
            end else begin
              ok_d = 1'b0;
            end
          end
          F7_FMVWX: op_d = OP_FMV_W_X;
          F7_FSGNJ: begin
            case (f3)
              3'd0: op_d = OP_FSGNJ;
              3'd1: op_d = OP_FSGNJN;
              3'd2: op_d = OP_FSGNJX;
              default: ok_d = 1'b0;
            endcase
          end
          F7_FMINMX: begin
            case (f3)
              3'd0: op_d = OP_FMIN;
              3'd1: op_d = OP_FMAX;
              default: ok_d = 1'b0;
            endcase
          end
          F7_FCMP: begin
            case (f3)
              3'd2: op_d = OP_FEQ;
              3'd1: op_d = OP_FLT;
              3'd0: op_d = OP_FLE;
              default: ok_d = 1'b0;
            endcase
          end
          default: ok_d = 1'b0;
        endcase
      end
      GRP_FMA: begin
        fmt_d = FMT_R4;
        case (s1_i.inst[3:2])
          2'd0: op_d = OP_FMADD;
          2'd1: op_d = OP_FMSUB;
          2'd2: op_d = OP_FNMSUB;
          default: op_d = OP_FNMADD;
        endcase
      end
      default: ok_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= s1_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    inst_q <= s1_i.inst;
    pc_q   <= s1_i.pc;
    ok_q   <= ok_d;
    op_q   <= op_d;
    fmt_q  <= fmt_d;
  end

  assign s2_o = '{vld: vld_q, inst: inst_q, pc: pc_q, ok: ok_q, op: op_q, fmt: fmt_q};

endmodule
`default_nettype wire

@@ hdl/rvdec_pack.sv @@
// Third decode stage: builds register numbers, immediate and next pc into the output registers.
`timescale 1ns / 1ps
`default_nettype none
module rvdec_pack
  import rvdec_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire s2_t                 s2_i,
  output logic                     done_o,
  output logic                     valid_res_o,
  output logic [OpW-1:0]           op_id_o,
  output logic [RegW-1:0]          rd_o,
  output logic [RegW-1:0]          rs1_o,
  output logic [RegW-1:0]          rs2_o,
  output logic [RegW-1:0]          rs3_o,
  output logic signed [XlenW-1:0]  imm_o,
  output logic [XlenW-1:0]         next_pc_o
);

  logic [XlenW-1:0] x;
  logic             done_q;
  logic             ok_q;
  logic [OpW-1:0]   op_d, op_q;
  logic [RegW-1:0]  rd_d, rd_q, rs1_d, rs1_q, rs2_d, rs2_q, rs3_d, rs3_q;
  logic [XlenW-1:0] imm_d, imm_q, npc_d, npc_q;

  assign x = s2_i.inst;

  always_comb begin
    rd_d  = '0;
    rs1_d = '0;
    rs2_d = '0;
    rs3_d = '0;
    imm_d = '0;
    case (s2_i.fmt)
      FMT_I: begin
        rd_d  = x[11:7];
        rs1_d = x[19:15];
        imm_d = {{20{x[31]}}, x[31:20]};
      end
      FMT_S: begin
        rs1_d = x[19:15];
        rs2_d = x[24:20];
        imm_d = {{20{x[31]}}, x[31:25], x[11:7]};
      end
      FMT_B: begin
        rs1_d = x[19:15];
        rs2_d = x[24:20];
        imm_d = {{19{x[31]}}, x[31], x[7], x[30:25], x[11:8], 1'b0};
      end
      FMT_U: begin
        rd_d  = x[11:7];
        imm_d = {x[31:12], 12'd0};
      end
      FMT_J: begin
        rd_d  = x[11:7];
        imm_d = {{11{x[31]}}, x[31], x[19:12], x[20], x[30:21], 1'b0};
      end
      FMT_R: begin
        rd_d  = x[11:7];
        rs1_d = x[19:15];
        rs2_d = x[24:20];
      end
      FMT_R4: begin
        rd_d  = x[11:7];
        rs1_d = x[19:15];
        rs2_d = x[24:20];
        rs3_d = x[31:27];
      end
      FMT_SYS: begin
        rd_d  = x[11:7];
        rs1_d = x[19:15];
      end
      default: begin
        rd_d = '0;
      end
    endcase
    op_d  = s2_i.op;
    npc_d = s2_i.pc + XlenW'(4);
    if (!s2_i.ok) begin
      rd_d  = '0;
      rs1_d = '0;
      rs2_d = '0;
      rs3_d = '0;
      imm_d = '0;
      op_d  = OP_LB;
      npc_d = s2_i.pc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q  <= s2_i.ok;
    op_q  <= op_d;
    rd_q  <= rd_d;
    rs1_q <= rs1_d;
    rs2_q <= rs2_d;
    rs3_q <= rs3_d;
    imm_q <= imm_d;
    npc_q <= npc_d;
  end

  assign done_o      = done_q;
  assign valid_res_o = ok_q;
  assign op_id_o     = op_q;
  assign rd_o        = rd_q;
  assign rs1_o       = rs1_q;
  assign rs2_o       = rs2_q;
  assign rs3_o       = rs3_q;
  assign imm_o       = signed'(imm_q);
  assign next_pc_o   = npc_q;

endmodule
`default_nettype wire

@@ hdl/rv32imf_instruction_decoder_core.sv @@
// Top level of the RV32IMF instruction decoder: enable registers and the three decode stages.
`timescale 1ns / 1ps
`default_nettype none
`include "rv32imf_instruction_decoder_core_defines.svh"
// The decoder takes one instruction word with its pc in every clock cycle and busy_o stays
// low. Each word comes out on the result ports once it has passed the three register stages,
// marked by done_o for one cycle, in the order the words went in. The register stages of the
// pipeline are opcode group sort, operation select, and field packing with the pc adder. The
// receiver cannot stall, and the pipeline never does either. The enable registers should be
// written only while no word is in flight.
module rv32imf_instruction_decoder_core
  import rvdec_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [XlenW-1:0]   inst_i,
  input  wire logic [XlenW-1:0]   pc_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic               cfg_data_i,
  output logic                    done_o,
  output logic                    valid_res_o,
  output logic [OpW-1:0]          op_id_o,
  output logic [RegW-1:0]         rd_o,
  output logic [RegW-1:0]         rs1_o,
  output logic [RegW-1:0]         rs2_o,
  output logic [RegW-1:0]         rs3_o,
  output logic signed [XlenW-1:0] imm_o,
  output logic [XlenW-1:0]        next_pc_o
);

  logic en_mul_div_q, en_csr_q, en_float_q;
  logic take;
  s1_t  s1;
  s2_t  s2;

  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_mul_div_q <= 1'b1;
      en_csr_q     <= 1'b1;
      en_float_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MUL_DIV: en_mul_div_q <= cfg_data_i;
        CFG_CSR:     en_csr_q     <= cfg_data_i;
        CFG_FLOAT:   en_float_q   <= cfg_data_i;
        default:     en_float_q   <= en_float_q;
      endcase
    end
  end

  rvdec_classify u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .inst_i     (inst_i),
    .pc_i       (pc_i),
    .en_float_i (en_float_q),
    .s1_o       (s1)
  );

  rvdec_opsel u_opsel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_i         (s1),
    .en_mul_div_i (en_mul_div_q),
    .en_csr_i     (en_csr_q),
    .s2_o         (s2)
  );

  rvdec_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_i        (s2),
    .done_o      (done_o),
    .valid_res_o (valid_res_o),
    .op_id_o     (op_id_o),
    .rd_o        (rd_o),
    .rs1_o       (rs1_o),
    .rs2_o       (rs2_o),
    .rs3_o       (rs3_o),
    .imm_o       (imm_o),
    .next_pc_o   (next_pc_o)
  );

  `RVDEC_ASSERT_AFTER3(a_latency, clk_i, rst_ni, take, done_o)
  `RVDEC_ASSERT_IMPLY(a_illegal_zero, clk_i, rst_ni, done_o && !valid_res_o,
    op_id_o == OP_LB && rd_o == '0 && rs1_o == '0 && rs2_o == '0 && rs3_o == '0 &&
    imm_o == '0)
  `RVDEC_ASSERT_IMPLY(a_op_range, clk_i, rst_ni, done_o && valid_res_o,
    op_id_o <= OP_FNMADD)
  `RVDEC_ASSERT_IMPLY(a_store_branch_rd, clk_i, rst_ni,
    done_o && valid_res_o && (op_id_o == OP_SB || op_id_o == OP_SH || op_id_o == OP_SW ||
    op_id_o == OP_FSW || (op_id_o >= OP_BEQ && op_id_o <= OP_BGEU)), rd_o == '0)
  `RVDEC_ASSERT_IMPLY(a_rs3_fma_only, clk_i, rst_ni, done_o && rs3_o != '0,
    valid_res_o && op_id_o >= OP_FMADD)

endmodule
`default_nettype wire
